FILE: hw/rtl/cigar_to_coverage_intervals_assert.svh
// assertion macros used by the checker file of the cigar coverage block
// no dependencies; clock and reset are taken as clk and arst_n in the caller
`ifndef CIGAR_TO_COVERAGE_INTERVALS_ASSERT_SVH
`define CIGAR_TO_COVERAGE_INTERVALS_ASSERT_SVH

// same-cycle implication
`define CIGCOV_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define CIGCOV_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: hw/rtl/cigcov_pkg.sv
// shared widths, status codes and character codes of the cigar coverage block
// no dependencies
package cigcov_pkg;

	localparam int OUT_W  = 30;
	localparam int CHAR_W = 8;
	localparam int EXT_W  = 16;
	localparam int STAT_W = 2;

	typedef logic [STAT_W-1:0] status_t;
	typedef logic [CHAR_W-1:0] char_t;

	localparam status_t STAT_INTERVAL  = 2'd0;
	localparam status_t STAT_EMPTY     = 2'd1;
	localparam status_t STAT_MALFORMED = 2'd2;
	localparam status_t STAT_OVERFLOW  = 2'd3;

	// bit positions in the error flags
	localparam int ERR_MAL = 0;
	localparam int ERR_OVF = 1;

	localparam char_t CH_0  = 8'h30;
	localparam char_t CH_9  = 8'h39;
	localparam char_t CH_M  = 8'h4D;
	localparam char_t CH_I  = 8'h49;
	localparam char_t CH_D  = 8'h44;
	localparam char_t CH_N  = 8'h4E;
	localparam char_t CH_S  = 8'h53;
	localparam char_t CH_H  = 8'h48;
	localparam char_t CH_P  = 8'h50;
	localparam char_t CH_X  = 8'h58;
	localparam char_t CH_EQ = 8'h3D;

endpackage

FILE: hw/rtl/cigcov_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cigcov_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: hw/rtl/cigar_to_coverage_intervals.sv
// top level of the cigar coverage interval extractor
// depends on cigcov_pkg and cigcov_ram
//
// Parses a read's CIGAR string one character per cycle (in_ready stays high while parsing),
// tracks the genome position, and writes each nonzero M run, up to MAX_BLOCKS of them, into a
// block ram as a covered interval. After the request carrying last_of_read, input stalls while
// results go out: a decision state, then either one result (errors, no coverage), one extended
// interval from the S_EXT state when extension_length is nonzero, or the stored blocks read back
// from the ram one by one (address state S_BRD, then registered read data in S_BWT), all further
// held by out_ready.
// extension_length may only be written while no read is in flight.
module cigar_to_coverage_intervals #(
	parameter int MAX_BLOCKS = 32,
	parameter int POS_BITS   = 30
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cigcov_pkg::EXT_W-1:0] extension_length,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [cigcov_pkg::CHAR_W-1:0] cigar_char,
	input  logic                        first_of_read,
	input  logic                        last_of_read,
	input  logic [cigcov_pkg::OUT_W-1:0] read_start,
	input  logic                        reverse_strand,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [cigcov_pkg::OUT_W-1:0] interval_begin,
	output logic [cigcov_pkg::OUT_W-1:0] interval_finish,
	output logic                        strand_out,
	output logic [cigcov_pkg::STAT_W-1:0] status,
	output logic                        last_result
);

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int RW = POS_BITS + 2;
	localparam int SW = POS_BITS + 3;
	localparam int OW = cigcov_pkg::OUT_W;
	localparam int DW = 2 * OW;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;
	localparam logic [CW-1:0]       BLK_MAX = CW'(MAX_BLOCKS);

	localparam logic [2:0] S_PARSE  = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_EXT    = 3'd2;
	localparam logic [2:0] S_BRD    = 3'd3;
	localparam logic [2:0] S_BWT    = 3'd4;

	logic [2:0]                   state_q, state_d;
	logic [cigcov_pkg::EXT_W-1:0] ext_q;

	logic                expect_q, run_dummy;
	logic [POS_BITS-1:0] run_q, gpos_q, left_q;
	logic [RW-1:0]       right_q;
	logic                strand_q, seen_q, bover_q;
	logic [CW-1:0]       count_q;
	logic [1:0]          err_q;

	logic                b_expect, b_strand, b_seen, b_bover;
	logic [POS_BITS-1:0] b_run, b_gpos, b_left;
	logic [RW-1:0]       b_right;
	logic [CW-1:0]       b_count;
	logic [1:0]          b_err;

	logic                n_expect, n_seen, n_bover;
	logic [POS_BITS-1:0] n_run, n_gpos, n_left;
	logic [RW-1:0]       n_right;
	logic [CW-1:0]       n_count;
	logic [1:0]          n_err;

	logic                is_digit, is_op, blk_wr;
	logic [POS_BITS+3:0] run_x, prod;
	logic [POS_BITS:0]   sum_w, fin_w;

	logic                in_acc, slot_free;
	logic [CW-1:0]       kidx_q, kidx_d;
	logic [POS_BITS:0]   start_q, start_d;
	logic signed [SW-1:0] right_x, ext_x, rev_start;
	logic [POS_BITS+1:0] ext_fin;

	logic                ld, clr;
	logic [OW-1:0]       ld_begin, ld_finish;
	cigcov_pkg::status_t ld_status;
	logic                ld_last;
	logic [DW-1:0]       rd_data;

	logic                out_valid_q, strand_out_q, last_q;
	logic [OW-1:0]       begin_q, finish_q;
	cigcov_pkg::status_t status_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_PARSE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign run_dummy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			ext_q <= extension_length;
		end
	end

	// parser state after the optional start-of-read clear
	always_comb begin
		if (first_of_read) begin
			b_expect = 1'b0;
			b_run    = '0;
			b_gpos   = POS_BITS'(read_start);
			b_strand = reverse_strand;
			b_left   = POS_MAX;
			b_right  = '0;
			b_count  = '0;
			b_err    = '0;
			b_seen   = 1'b0;
			b_bover  = 1'b0;
		end else begin
			b_expect = expect_q;
			b_run    = run_q;
			b_gpos   = gpos_q;
			b_strand = strand_q;
			b_left   = left_q;
			b_right  = right_q;
			b_count  = count_q;
			b_err    = err_q;
			b_seen   = seen_q;
			b_bover  = bover_q;
		end
	end

	always_comb begin
		is_digit = cigar_char inside {[cigcov_pkg::CH_0:cigcov_pkg::CH_9]};
		is_op    = cigar_char inside {cigcov_pkg::CH_M, cigcov_pkg::CH_I, cigcov_pkg::CH_D,
			cigcov_pkg::CH_N, cigcov_pkg::CH_S, cigcov_pkg::CH_H, cigcov_pkg::CH_P,
			cigcov_pkg::CH_X, cigcov_pkg::CH_EQ};
		// run * 10 + digit
		run_x = (POS_BITS+4)'(b_run);
		prod  = (run_x << 3) + (run_x << 1)
			+ (POS_BITS+4)'(cigar_char - cigcov_pkg::CH_0);
		sum_w = (POS_BITS+1)'(b_gpos) + (POS_BITS+1)'(b_run);
		fin_w = sum_w - (POS_BITS+1)'(1);

		n_expect = b_expect;
		n_run    = b_run;
		n_gpos   = b_gpos;
		n_left   = b_left;
		n_right  = b_right;
		n_count  = b_count;
		n_err    = b_err;
		n_seen   = b_seen;
		n_bover  = b_bover;
		blk_wr   = 1'b0;

		if (is_digit) begin
			if (|prod[POS_BITS+3:POS_BITS]) begin
				n_run = POS_MAX;
				n_err[cigcov_pkg::ERR_OVF] = 1'b1;
			end else begin
				n_run = prod[POS_BITS-1:0];
			end
			n_expect = 1'b0;
		end else if (is_op && !b_expect) begin
			if (cigar_char == cigcov_pkg::CH_M) begin
				n_left  = (!b_seen || b_gpos < b_left) ? b_gpos : b_left;
				n_seen  = 1'b1;
				n_right = RW'(sum_w) - RW'(1);
				if (b_run != '0) begin
					if (b_count < BLK_MAX) begin
						blk_wr  = 1'b1;
						n_count = b_count + CW'(1);
					end else begin
						n_bover = 1'b1;
					end
				end
			end
			if (cigar_char == cigcov_pkg::CH_M || cigar_char == cigcov_pkg::CH_D ||
				cigar_char == cigcov_pkg::CH_N) begin
				if (sum_w[POS_BITS]) begin
					n_gpos = POS_MAX;
					n_err[cigcov_pkg::ERR_OVF] = 1'b1;
				end else begin
					n_gpos = sum_w[POS_BITS-1:0];
				end
			end
			n_run    = '0;
			n_expect = 1'b1;
		end else begin
			n_err[cigcov_pkg::ERR_MAL] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b0;
			run_q    <= '0;
			gpos_q   <= '0;
			strand_q <= 1'b0;
			left_q   <= POS_MAX;
			right_q  <= '0;
			count_q  <= '0;
			err_q    <= '0;
			seen_q   <= 1'b0;
			bover_q  <= 1'b0;
		end else if (clr) begin
			expect_q <= 1'b0;
			run_q    <= '0;
			gpos_q   <= '0;
			strand_q <= 1'b0;
			left_q   <= POS_MAX;
			right_q  <= '0;
			count_q  <= '0;
			err_q    <= '0;
			seen_q   <= 1'b0;
			bover_q  <= 1'b0;
		end else if (in_acc) begin
			expect_q <= n_expect;
			run_q    <= n_run;
			gpos_q   <= n_gpos;
			strand_q <= b_strand;
			left_q   <= n_left;
			right_q  <= n_right;
			count_q  <= n_count;
			err_q    <= n_err;
			seen_q   <= n_seen;
			bover_q  <= n_bover;
		end
	end

	cigcov_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_BLOCKS)
	) u_blocks (
		.clk    (clk),
		.wr_en  (in_acc && blk_wr),
		.wr_addr(b_count[AW-1:0]),
		.wr_data({OW'(b_gpos), OW'(fin_w)}),
		.rd_addr(kidx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// extended interval arithmetic
	always_comb begin
		right_x   = SW'($signed(right_q));
		ext_x     = SW'($signed({1'b0, ext_q}));
		rev_start = right_x - ext_x + $signed(SW'(1));
		if (!strand_q) begin
			start_d = (POS_BITS+1)'(left_q);
		end else if (rev_start[SW-1]) begin
			start_d = (POS_BITS+1)'(1);
		end else begin
			start_d = rev_start[POS_BITS:0];
		end
		ext_fin = (POS_BITS+2)'(start_q) + (POS_BITS+2)'(ext_q) - (POS_BITS+2)'(1);
	end

	// emission sequencer
	always_comb begin
		state_d   = state_q;
		kidx_d    = kidx_q;
		ld        = 1'b0;
		clr       = 1'b0;
		ld_begin  = '0;
		ld_finish = '0;
		ld_status = cigcov_pkg::STAT_INTERVAL;
		ld_last   = 1'b1;
		case (state_q)
			S_PARSE: begin
				if (in_acc && last_of_read) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (slot_free) begin
					if (err_q[cigcov_pkg::ERR_MAL]) begin
						ld        = 1'b1;
						ld_status = cigcov_pkg::STAT_MALFORMED;
					end else if (err_q[cigcov_pkg::ERR_OVF]) begin
						ld        = 1'b1;
						ld_status = cigcov_pkg::STAT_OVERFLOW;
					end else if (ext_q != '0) begin
						if (!seen_q) begin
							ld        = 1'b1;
							ld_status = cigcov_pkg::STAT_EMPTY;
						end else begin
							state_d = S_EXT;
						end
					end else if (bover_q) begin
						ld        = 1'b1;
						ld_status = cigcov_pkg::STAT_OVERFLOW;
					end else if (count_q == '0) begin
						ld        = 1'b1;
						ld_status = cigcov_pkg::STAT_EMPTY;
					end else begin
						kidx_d  = '0;
						state_d = S_BRD;
					end
					if (ld) begin
						clr     = 1'b1;
						state_d = S_PARSE;
					end
				end
			end
			S_EXT: begin
				if (slot_free) begin
					ld = 1'b1;
					if (ext_fin > (POS_BITS+2)'(POS_MAX)) begin
						ld_status = cigcov_pkg::STAT_OVERFLOW;
					end else begin
						ld_begin  = OW'(start_q);
						ld_finish = OW'(ext_fin);
					end
					clr     = 1'b1;
					state_d = S_PARSE;
				end
			end
			S_BRD: begin
				state_d = S_BWT;
			end
			S_BWT: begin
				if (slot_free) begin
					ld        = 1'b1;
					ld_begin  = rd_data[DW-1:OW];
					ld_finish = rd_data[OW-1:0];
					ld_last   = (kidx_q + CW'(1)) == count_q;
					if (ld_last) begin
						clr     = 1'b1;
						state_d = S_PARSE;
					end else begin
						kidx_d  = kidx_q + CW'(1);
						state_d = S_BRD;
					end
				end
			end
			default: begin
				state_d = S_PARSE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_PARSE;
			kidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kidx_q  <= kidx_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			start_q <= start_d;
		end
		if (ld) begin
			begin_q      <= ld_begin;
			finish_q     <= ld_finish;
			strand_out_q <= strand_q;
			status_q     <= ld_status;
			last_q       <= ld_last | run_dummy;
		end
	end

	assign out_valid       = out_valid_q;
	assign interval_begin  = begin_q;
	assign interval_finish = finish_q;
	assign strand_out      = strand_out_q;
	assign status          = status_q;
	assign last_result     = last_q;

endmodule

FILE: hw/rtl/cigcov_checker.sv
// port-level checker for the cigar coverage block, bound to its top level
// depends on cigcov_pkg and cigar_to_coverage_intervals_assert.svh
`include "cigar_to_coverage_intervals_assert.svh"

module cigcov_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          last_of_read,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [cigcov_pkg::OUT_W-1:0]  interval_begin,
	input logic [cigcov_pkg::OUT_W-1:0]  interval_finish,
	input logic [cigcov_pkg::STAT_W-1:0] status,
	input logic                          last_result
);

	logic                                              not_interval;
	logic [2*cigcov_pkg::OUT_W+cigcov_pkg::STAT_W:0]   out_payload;

	assign not_interval = out_valid && status != cigcov_pkg::STAT_INTERVAL;
	assign out_payload  = {interval_begin, interval_finish, status, last_result};

	// a stalled result holds
	`CIGCOV_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

	// no new request is taken right after the end of a read
	`CIGCOV_CHECK_NEXT(a_stall_after_last, in_valid && in_ready && last_of_read, !in_ready)

	// any non-interval status is the only result of its read
	`CIGCOV_CHECK(a_status_last, not_interval, last_result)

	// non-interval results carry zero positions
	`CIGCOV_CHECK(a_status_zero, not_interval, interval_begin == '0 && interval_finish == '0)

endmodule

bind cigar_to_coverage_intervals cigcov_checker u_cigcov_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.last_of_read   (last_of_read),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.interval_begin (interval_begin),
	.interval_finish(interval_finish),
	.status         (status),
	.last_result    (last_result)
);

FILE: tb/sv/cigar_to_coverage_intervals_tb.sv
// self-checking bench for cigar_to_coverage_intervals: feeds cigar strings one character
// per request and checks every emitted interval against a parser model kept in the bench
// depends on cigcov_pkg and the rtl of the block
`timescale 1ns / 1ps

module cigar_to_coverage_intervals_tb;

	localparam int MAX_BLOCKS = 32;
	localparam longint POS_MAX = 64'h3FFF_FFFF;
	localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 8;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		cigcov_pkg::char_t          ch;
		bit                         is_first;
		bit                         is_last;
		bit [cigcov_pkg::OUT_W-1:0] start;
		bit                         rev;
	} cigar_req_t;

	typedef struct packed {
		logic [cigcov_pkg::OUT_W-1:0] first_pos;
		logic [cigcov_pkg::OUT_W-1:0] last_pos;
		logic                         strand;
		cigcov_pkg::status_t          stat;
		logic                         is_last;
	} interval_t;

	class coverage_scoreboard;
		bit [cigcov_pkg::EXT_W-1:0] ext_len;
		bit after_op;
		longint run_len, gpos, leftmost, rightmost;
		bit rev;
		int nblocks;
		longint blk_lo [MAX_BLOCKS];
		longint blk_hi [MAX_BLOCKS];
		bit [1:0] err;
		bit match_seen, blocks_full;
		interval_t intervals_due [$];
		int fails;

		function new();
			ext_len = 0;
			fails = 0;
			reset_parser();
		endfunction

		function void reset_parser();
			after_op = 0;
			run_len = 0;
			gpos = 0;
			rev = 0;
			leftmost = POS_MAX;
			rightmost = 0;
			nblocks = 0;
			err = 0;
			match_seen = 0;
			blocks_full = 0;
		endfunction

		function void queue_interval(longint lo, longint hi, cigcov_pkg::status_t st, bit last);
			interval_t r;
			r.first_pos = lo[cigcov_pkg::OUT_W-1:0];
			r.last_pos = hi[cigcov_pkg::OUT_W-1:0];
			r.strand = rev;
			r.stat = st;
			r.is_last = last;
			intervals_due.insert(intervals_due.size(), r);
		endfunction

		function void note_request(cigar_req_t it);
			longint v, len, start, fin, xlen;
			bit is_op;
			if (it.is_first) begin
				reset_parser();
				gpos = longint'(it.start);
				rev = it.rev;
			end
			case (it.ch)
				cigcov_pkg::CH_M, cigcov_pkg::CH_I, cigcov_pkg::CH_D, cigcov_pkg::CH_N,
				cigcov_pkg::CH_S, cigcov_pkg::CH_H, cigcov_pkg::CH_P, cigcov_pkg::CH_X,
				cigcov_pkg::CH_EQ: is_op = 1;
				default: is_op = 0;
			endcase
			if (it.ch >= cigcov_pkg::CH_0 && it.ch <= cigcov_pkg::CH_9) begin
				v = run_len * 10 + longint'(it.ch - cigcov_pkg::CH_0);
				if (v > POS_MAX) begin
					v = POS_MAX;
					err[cigcov_pkg::ERR_OVF] = 1;
				end
				run_len = v;
				after_op = 0;
			end else if (is_op && !after_op) begin
				len = run_len;
				if (it.ch == cigcov_pkg::CH_M) begin
					if (gpos < leftmost || !match_seen)
						leftmost = (match_seen && leftmost < gpos) ? leftmost : gpos;
					match_seen = 1;
					rightmost = gpos + len - 1;
					if (len > 0) begin
						if (nblocks < MAX_BLOCKS) begin
							blk_lo[nblocks] = gpos;
							blk_hi[nblocks] = gpos + len - 1;
							nblocks++;
						end else begin
							blocks_full = 1;
						end
					end
				end
				if (it.ch == cigcov_pkg::CH_M || it.ch == cigcov_pkg::CH_D ||
						it.ch == cigcov_pkg::CH_N) begin
					gpos += len;
					if (gpos > POS_MAX) begin
						gpos = POS_MAX;
						err[cigcov_pkg::ERR_OVF] = 1;
					end
				end
				run_len = 0;
				after_op = 1;
			end else begin
				err[cigcov_pkg::ERR_MAL] = 1;
			end

			if (it.is_last) begin
				xlen = longint'(ext_len);
				if (err[cigcov_pkg::ERR_MAL]) begin
					queue_interval(0, 0, cigcov_pkg::STAT_MALFORMED, 1);
				end else if (err[cigcov_pkg::ERR_OVF]) begin
					queue_interval(0, 0, cigcov_pkg::STAT_OVERFLOW, 1);
				end else if (xlen > 0) begin
					if (!match_seen) begin
						queue_interval(0, 0, cigcov_pkg::STAT_EMPTY, 1);
					end else begin
						start = rev ? rightmost - (xlen - 1) : leftmost;
						// negative start clamps to 1, an exact 0 stays
						if (start < 0)
							start = 1;
						fin = start + xlen - 1;
						if (fin > POS_MAX)
							queue_interval(0, 0, cigcov_pkg::STAT_OVERFLOW, 1);
						else
							queue_interval(start, fin, cigcov_pkg::STAT_INTERVAL, 1);
					end
				end else if (blocks_full) begin
					queue_interval(0, 0, cigcov_pkg::STAT_OVERFLOW, 1);
				end else if (nblocks == 0) begin
					queue_interval(0, 0, cigcov_pkg::STAT_EMPTY, 1);
				end else begin
					for (int k = 0; k < nblocks; k++)
						queue_interval(blk_lo[k], blk_hi[k], cigcov_pkg::STAT_INTERVAL,
							k == nblocks - 1);
				end
				reset_parser();
			end
		endfunction

		function void check_result(interval_t got);
			interval_t want;
			if (intervals_due.size() == 0) begin
				fails++;
				$display("%0t: unrequested result begin %0d finish %0d strand %0d",
					$time, got.first_pos, got.last_pos, got.strand);
				$display("%0t: unrequested result status %0d last %0d",
					$time, got.stat, got.is_last);
				return;
			end
			want = intervals_due.pop_front();
			if (got.first_pos !== want.first_pos || got.last_pos !== want.last_pos ||
					got.strand !== want.strand || got.stat !== want.stat ||
					got.is_last !== want.is_last) begin
				fails++;
				$display("%0t: expected begin %0d finish %0d strand %0d status %0d last %0d",
					$time, want.first_pos, want.last_pos, want.strand, want.stat,
					want.is_last);
				$display("%0t: actual   begin %0d finish %0d strand %0d status %0d last %0d",
					$time, got.first_pos, got.last_pos, got.strand, got.stat, got.is_last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [cigcov_pkg::EXT_W-1:0] extension_length;
	logic in_valid;
	logic in_ready;
	logic [cigcov_pkg::CHAR_W-1:0] cigar_char;
	logic first_of_read;
	logic last_of_read;
	logic [cigcov_pkg::OUT_W-1:0] read_start;
	logic reverse_strand;
	logic out_valid;
	logic out_ready;
	logic [cigcov_pkg::OUT_W-1:0] interval_begin;
	logic [cigcov_pkg::OUT_W-1:0] interval_finish;
	logic strand_out;
	logic [cigcov_pkg::STAT_W-1:0] status;
	logic last_result;

	coverage_scoreboard sb;
	bit quiet;
	bit hold_req;

	cigar_to_coverage_intervals u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.extension_length(extension_length),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cigar_char(cigar_char),
		.first_of_read(first_of_read),
		.last_of_read(last_of_read),
		.read_start(read_start),
		.reverse_strand(reverse_strand),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.interval_begin(interval_begin),
		.interval_finish(interval_finish),
		.strand_out(strand_out),
		.status(status),
		.last_result(last_result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic cigcov_pkg::char_t pick_op();
		case ($urandom_range(0, 8))
			0: return cigcov_pkg::CH_M;
			1: return cigcov_pkg::CH_I;
			2: return cigcov_pkg::CH_D;
			3: return cigcov_pkg::CH_N;
			4: return cigcov_pkg::CH_S;
			5: return cigcov_pkg::CH_H;
			6: return cigcov_pkg::CH_P;
			7: return cigcov_pkg::CH_X;
			default: return cigcov_pkg::CH_EQ;
		endcase
	endfunction

	task automatic send(cigar_req_t it);
		if (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cigar_char <= it.ch;
		first_of_read <= it.is_first;
		last_of_read <= it.is_last;
		read_start <= it.start;
		reverse_strand <= it.rev;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(it);
	endtask

	task automatic send_chars(cigcov_pkg::char_t q [$], bit [cigcov_pkg::OUT_W-1:0] start,
			bit rev, bit mark_first, bit mark_last);
		cigar_req_t it;
		for (int i = 0; i < q.size(); i++) begin
			it.ch = q[i];
			it.is_first = mark_first && i == 0;
			it.is_last = mark_last && i == q.size() - 1;
			it.start = start;
			it.rev = rev;
			send(it);
		end
	endtask

	task automatic send_text(string s, bit [cigcov_pkg::OUT_W-1:0] start, bit rev);
		cigcov_pkg::char_t q [$];
		for (int i = 0; i < s.len(); i++)
			q.insert(q.size(), cigcov_pkg::char_t'(s[i]));
		send_chars(q, start, rev, 1'b1, 1'b1);
	endtask

	// mostly well-formed reads with random lengths; some get a stray character or a
	// doubled operation, and a few lose their first or last marker
	task automatic random_read(output int sent);
		cigcov_pkg::char_t q [$];
		string num;
		int nops, pick;
		longint pos;
		bit [cigcov_pkg::OUT_W-1:0] start;
		nops = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
		for (int k = 0; k < nops; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				num = "";
			else if (pick < 80)
				num = $sformatf("%0d", $urandom_range(0, 99));
			else if (pick < 96)
				num = $sformatf("%0d", $urandom_range(100, 99999));
			else
				num = "9999999999";
			for (int i = 0; i < num.len(); i++)
				q.insert(q.size(), cigcov_pkg::char_t'(num[i]));
			q.insert(q.size(), ($urandom_range(0, 99) < 40) ? cigcov_pkg::CH_M : pick_op());
		end
		if ($urandom_range(0, 9) == 0)
			q.insert(q.size(),
				cigcov_pkg::char_t'(cigcov_pkg::CH_0 + cigcov_pkg::char_t'($urandom_range(0, 9))));
		if ($urandom_range(0, 99) < 15) begin
			pick = $urandom_range(0, q.size() - 1);
			if ($urandom_range(0, 1))
				q[pick] = cigcov_pkg::char_t'($urandom_range(0, 255));
			else
				q.insert(pick, pick_op());
		end
		case ($urandom_range(0, 9))
			0: pos = 1;
			1: pos = POS_MAX - longint'($urandom_range(0, 2000));
			2: pos = longint'($urandom_range(1, POS_MAX));
			default: pos = longint'($urandom_range(1, 20000));
		endcase
		start = pos[cigcov_pkg::OUT_W-1:0];
		send_chars(q, start, $urandom_range(0, 1) == 1, $urandom_range(0, 19) != 0,
			$urandom_range(0, 19) != 0);
		sent = q.size();
	endtask

	task automatic write_ext(bit [cigcov_pkg::EXT_W-1:0] value);
		cfg_valid <= 1'b1;
		extension_length <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.ext_len = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.intervals_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls, plus one long hold-off that backs up the input
	initial begin
		int hold_left;
		interval_t got;
		hold_left = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.first_pos = interval_begin;
				got.last_pos = interval_finish;
				got.strand = strand_out;
				got.stat = status;
				got.is_last = last_result;
				sb.check_result(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || $urandom_range(0, 99) >= 8;
			end
		end
	end

	initial begin
		int budget, used;
		int unsigned ext_pick;
		sb = new();
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		extension_length <= '0;
		in_valid <= 1'b0;
		cigar_char <= '0;
		first_of_read <= 1'b0;
		last_of_read <= 1'b0;
		read_start <= '0;
		reverse_strand <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// block mode: every operation, zero-length match, grammar errors, overflow
		write_ext('0);
		send_text("H1S1P1X1=1I1N2M1D3M", 1, 1'b0);
		send_text("0M", POS_MAX[cigcov_pkg::OUT_W-1:0], 1'b1);
		send_text("MM", 500, 1'b0);
		send_text("MZ", 500, 1'b1);
		send_text("2M", POS_MAX[cigcov_pkg::OUT_W-1:0], 1'b0);
		send_text("7", 42, 1'b1);
		send_text({32{"1M"}}, 1000, 1'b1);
		send_text({33{"1M"}}, 1000, 1'b0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			ext_pick = $urandom_range(2, 65534);
			case (ph)
				0: write_ext('1);
				1: write_ext(16'd100);
				2: write_ext(16'd1);
				3: write_ext(ext_pick[cigcov_pkg::EXT_W-1:0]);
				default: write_ext('0);
			endcase
			if (ph == 0) begin
				send_text("5S", 77, 1'b0);
				send_text("5M", POS_MAX[cigcov_pkg::OUT_W-1:0] - 10, 1'b0);
				send_text("3M", 9, 1'b1);
				// too many blocks only matters in block mode
				send_text({33{"1M"}}, 300, 1'b1);
			end
			if (ph == 1) begin
				// reverse extension lands exactly on position 0
				send_text("99M", 1, 1'b1);
				quiet = 1;
				hold_req = 1;
			end
			budget = 0;
			while (budget < 30) begin
				random_read(used);
				budget += used;
			end
			drain();
			quiet = 0;
		end

		if (sb.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
